>>> rtl/core/assert_macros.svh
// Assertion macros shared by the sorter core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SKTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SKTS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/core/skts_pkg.sv
// Types and constants of the stable key/tag sorter.
package skts_pkg;

  localparam int unsigned KEY_IN_W = 32;
  localparam int unsigned TAG_W    = 6;

  typedef struct packed {
    logic [KEY_IN_W-1:0] sort_key;
    logic [TAG_W-1:0]    entry_tag;
    logic                load_last;
  } in_word_t;

  typedef struct packed {
    logic [KEY_IN_W-1:0] sorted_key;
    logic [TAG_W-1:0]    sorted_tag;
    logic                emit_last;
  } out_word_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic insert;
    logic shift;
  } chain_ctrl_t;

endpackage

>>> rtl/core/skts_cell.sv
// One cell of the sorting chain: holds one entry, inserts or shifts toward the head.
module skts_cell #(
  parameter int unsigned KeyW = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  skts_pkg::chain_ctrl_t      ctrl_i,
  input  logic [KeyW-1:0]            new_key_i,
  input  logic [skts_pkg::TAG_W-1:0] new_tag_i,
  input  logic                       prev_take_i,
  input  logic                       prev_valid_i,
  input  logic [KeyW-1:0]            prev_key_i,
  input  logic [skts_pkg::TAG_W-1:0] prev_tag_i,
  input  logic                       next_valid_i,
  input  logic [KeyW-1:0]            next_key_i,
  input  logic [skts_pkg::TAG_W-1:0] next_tag_i,
  output logic                       take_o,
  output logic                       valid_o,
  output logic [KeyW-1:0]            key_o,
  output logic [skts_pkg::TAG_W-1:0] tag_o
);
  import skts_pkg::*;

  logic             valid_q, valid_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [TAG_W-1:0] tag_q, tag_d;

  // Strictly less keeps equal keys in load order.
  assign take_o = !valid_q || (new_key_i < key_q);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    tag_d   = tag_q;
    priority if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      key_d   = next_key_i;
      tag_d   = next_tag_i;
    end else if (ctrl_i.insert && take_o) begin
      if (prev_take_i) begin
        valid_d = prev_valid_i;
        key_d   = prev_key_i;
        tag_d   = prev_tag_i;
      end else begin
        valid_d = 1'b1;
        key_d   = new_key_i;
        tag_d   = new_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign tag_o   = tag_q;

endmodule

>>> rtl/core/skts_ctrl.sv
// Load/drain sequencer and fill counter of the sorter.
`include "assert_macros.svh"

module skts_ctrl #(
  parameter int unsigned SetSize = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  load_last_i,
  input  logic                  out_ready_i,
  input  logic                  head_valid_i,
  input  logic                  second_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  output logic                  out_last_o,
  output skts_pkg::chain_ctrl_t ctrl_o
);
  import skts_pkg::*;

  localparam int unsigned CntW = $clog2(SetSize);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            set_done;

  assign set_done = load_last_i || (count_q == CntW'(SetSize - 1));

  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    out_last_o    = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
      end
      ST_DRAIN: begin
        out_valid_o = head_valid_i;
        out_last_o  = !second_valid_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
    ctrl_o.insert = in_valid_i && in_ready_o;
    ctrl_o.shift  = out_valid_o && out_ready_i;
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    unique case (state_q)
      ST_LOAD: begin
        if (ctrl_o.insert) begin
          if (set_done) begin
            state_d = ST_DRAIN;
            count_d = '0;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (ctrl_o.shift && out_last_o) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  `SKTS_ASSERT_NEVER(a_no_load_while_drain, in_ready_o && out_valid_o, "load and drain overlap")
  `SKTS_ASSERT(a_last_starts_drain, ctrl_o.insert && load_last_i |=> out_valid_o, "no drain after last")
  `SKTS_ASSERT(a_drain_ends_in_load, ctrl_o.shift && out_last_o |=> in_ready_o, "no reload after last word")

endmodule

>>> rtl/core/stable_key_tag_sorter_core.sv
// Top level of the stable key/tag sorter: a chain of insertion cells plus its sequencer.
// Words are loaded one per cycle while no set drains; each new key is inserted at once into
// its sorted place in a chain of SET_SIZE cells, behind any equal keys already held. The word
// marked last, or the SET_SIZE-th word of a set, closes the set, and from the next cycle on the
// chain shifts its entries out of the head cell in ascending key order, one word per cycle
// while the sink is ready, flagging the final one. No word is taken while a set drains, so a
// new set is loaded only after the last entry of the previous one is out. Keys are compared
// on their low KEY_BITS bits.
`include "assert_macros.svh"

module stable_key_tag_sorter_core #(
  parameter int unsigned SET_SIZE = 64,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  skts_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output skts_pkg::out_word_t out_data_o
);
  import skts_pkg::*;

  chain_ctrl_t         ctrl;
  logic                out_last;
  logic [KEY_BITS-1:0] new_key;

  logic                take_w  [SET_SIZE];
  logic                valid_w [SET_SIZE];
  logic [KEY_BITS-1:0] key_w   [SET_SIZE];
  logic [TAG_W-1:0]    tag_w   [SET_SIZE];

  assign new_key = KEY_BITS'(in_data_i.sort_key);

  skts_ctrl #(
    .SetSize(SET_SIZE)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .load_last_i   (in_data_i.load_last),
    .out_ready_i   (out_ready_i),
    .head_valid_i  (valid_w[0]),
    .second_valid_i(valid_w[1]),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_last_o    (out_last),
    .ctrl_o        (ctrl)
  );

  for (genvar i = 0; i < SET_SIZE; i++) begin : g_cell
    logic                p_take, p_valid, n_valid;
    logic [KEY_BITS-1:0] p_key, n_key;
    logic [TAG_W-1:0]    p_tag, n_tag;

    if (i == 0) begin : g_head
      assign p_take  = 1'b0;
      assign p_valid = 1'b0;
      assign p_key   = '0;
      assign p_tag   = '0;
    end else begin : g_body
      assign p_take  = take_w[i-1];
      assign p_valid = valid_w[i-1];
      assign p_key   = key_w[i-1];
      assign p_tag   = tag_w[i-1];
    end

    if (i == SET_SIZE - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_key   = '0;
      assign n_tag   = '0;
    end else begin : g_link
      assign n_valid = valid_w[i+1];
      assign n_key   = key_w[i+1];
      assign n_tag   = tag_w[i+1];
    end

    skts_cell #(
      .KeyW(KEY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_key_i   (new_key),
      .new_tag_i   (in_data_i.entry_tag),
      .prev_take_i (p_take),
      .prev_valid_i(p_valid),
      .prev_key_i  (p_key),
      .prev_tag_i  (p_tag),
      .next_valid_i(n_valid),
      .next_key_i  (n_key),
      .next_tag_i  (n_tag),
      .take_o      (take_w[i]),
      .valid_o     (valid_w[i]),
      .key_o       (key_w[i]),
      .tag_o       (tag_w[i])
    );
  end

  assign out_data_o.sorted_key = KEY_IN_W'(key_w[0]);
  assign out_data_o.sorted_tag = tag_w[0];
  assign out_data_o.emit_last  = out_last;

  `SKTS_ASSERT(a_head_in_order, out_valid_o && valid_w[1] |-> key_w[0] <= key_w[1], "head out of order")
  `SKTS_ASSERT(a_chain_packed, valid_w[1] |-> valid_w[0], "gap at chain head")

endmodule

>>> sim/sort_order_checker.sv
// Checker for the key/tag sorter: predicts the sorted output of each set and compares it.
module sort_order_checker
  import skts_pkg::*;
#(
  parameter int unsigned SET_SIZE = 64,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_word_t   out_word_i,
  output int unsigned mismatch_count_o,
  output int unsigned results_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KEY_IN_W-1:0] KEY_MASK =
    (KEY_BITS >= KEY_IN_W) ? '1 : ((KEY_IN_W'(1) << KEY_BITS) - 1);

  logic [KEY_IN_W-1:0] held_keys [$];
  logic [TAG_W-1:0]    held_tags [$];
  out_word_t           sorted_words_due [$];
  out_word_t           want;
  int unsigned         mismatches;

  // Stable insertion sort: move an entry left only past strictly greater keys.
  function automatic void sort_held_set();
    logic [KEY_IN_W-1:0] keys [$];
    logic [TAG_W-1:0]    tags [$];
    logic [KEY_IN_W-1:0] k_swap;
    logic [TAG_W-1:0]    t_swap;
    int                  j;
    keys = held_keys;
    tags = held_tags;
    for (int i = 1; i < keys.size(); i++) begin
      j = i;
      while (j > 0 && keys[j-1] > keys[j]) begin
        k_swap    = keys[j-1];
        t_swap    = tags[j-1];
        keys[j-1] = keys[j];
        tags[j-1] = tags[j];
        keys[j]   = k_swap;
        tags[j]   = t_swap;
        j--;
      end
    end
    for (int i = 0; i < keys.size(); i++) begin
      sorted_words_due.push_back('{sorted_key: keys[i], sorted_tag: tags[i],
                                   emit_last: 1'(i == keys.size() - 1)});
    end
    held_keys.delete();
    held_tags.delete();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_keys.delete();
      held_tags.delete();
      sorted_words_due.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      results_owed_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (sorted_words_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, got key %h tag %h last %b",
                   $time, out_word_i.sorted_key, out_word_i.sorted_tag,
                   out_word_i.emit_last);
          mismatches++;
        end else begin
          want = sorted_words_due.pop_front();
          if (out_word_i.sorted_key !== want.sorted_key) begin
            $display("%0t: sorted_key mismatch, expected %h, got %h",
                     $time, want.sorted_key, out_word_i.sorted_key);
            mismatches++;
          end
          if (out_word_i.sorted_tag !== want.sorted_tag) begin
            $display("%0t: sorted_tag mismatch, expected %h, got %h",
                     $time, want.sorted_tag, out_word_i.sorted_tag);
            mismatches++;
          end
          if (out_word_i.emit_last !== want.emit_last) begin
            $display("%0t: emit_last mismatch, expected %b, got %b",
                     $time, want.emit_last, out_word_i.emit_last);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        held_keys.push_back(in_word_i.sort_key & KEY_MASK);
        held_tags.push_back(in_word_i.entry_tag);
        // a full set closes even without the last flag
        if (in_word_i.load_last || held_keys.size() >= SET_SIZE) begin
          sort_held_set();
        end
      end
      mismatch_count_o <= mismatches;
      results_owed_o   <= sorted_words_due.size();
    end
  end

endmodule

>>> sim/stable_key_tag_sorter_core_tb.sv
// Testbench top for the key/tag sorter: drives sets of entries and gives the verdict.
module stable_key_tag_sorter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import skts_pkg::*;

  localparam int unsigned SET_SIZE = 64;
  localparam int unsigned KEY_BITS = 32;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  in_word_t    in_data     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  out_word_t   out_data;
  int unsigned mismatch_count;
  int unsigned results_owed;
  bit          calm        = 1'b0;

  always #5 clk_i = ~clk_i;

  stable_key_tag_sorter_core #(
    .SET_SIZE (SET_SIZE),
    .KEY_BITS (KEY_BITS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  sort_order_checker #(
    .SET_SIZE (SET_SIZE),
    .KEY_BITS (KEY_BITS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_word_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_word_i       (out_data),
    .mismatch_count_o (mismatch_count),
    .results_owed_o   (results_owed)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mix extremes, tie-prone small keys and full-range keys.
  function automatic logic [KEY_IN_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return '1;
      2, 3, 4: return KEY_IN_W'($urandom_range(0, 7));
      5: return {16'($urandom_range(0, 3)), 16'h0000};
      default: return KEY_IN_W'($urandom);
    endcase
  endfunction

  task automatic send_entry(input logic [KEY_IN_W-1:0] key, input logic [TAG_W-1:0] tag,
                            input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{sort_key: key, entry_tag: tag, load_last: last};
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Hold the sender until every sorted word has drained.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned set_no;
    int unsigned set_len;
    bit          flag_last;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-entry sets at both extremes
    send_entry('1, 6'd63, 1'b1);
    send_entry('0, 6'd0, 1'b1);
    // equal keys keep their load order
    send_entry(32'h0001_0000, 6'd1, 1'b0);
    send_entry(32'h0001_0000, 6'd2, 1'b0);
    send_entry(32'h0001_0000, 6'd3, 1'b0);
    send_entry(32'h0001_0000, 6'd4, 1'b1);
    // reverse order
    send_entry('1, 6'd10, 1'b0);
    send_entry(32'h8000_0000, 6'd20, 1'b0);
    send_entry('0, 6'd30, 1'b1);
    // already sorted
    send_entry(32'h0000_0001, 6'd5, 1'b0);
    send_entry(32'h0000_0002, 6'd6, 1'b0);
    send_entry(32'h0000_0003, 6'd7, 1'b1);
    // mixed with ties
    send_entry(32'd5, 6'h2a, 1'b0);
    send_entry(32'd3, 6'h15, 1'b0);
    send_entry(32'd5, 6'h3f, 1'b0);
    send_entry(32'd0, 6'h00, 1'b0);
    send_entry(32'd3, 6'h01, 1'b0);
    send_entry('1, 6'h20, 1'b1);
    wait_drained();

    sent   = 0;
    set_no = 0;
    while (sent < 200) begin
      calm = ($urandom_range(0, 3) == 0);
      if (set_no == 3 || set_no == 9) begin
        set_len = SET_SIZE;
      end else if ($urandom_range(0, 5) == 0) begin
        set_len = $urandom_range(9, 20);
      end else begin
        set_len = $urandom_range(1, 8);
      end
      for (int i = 0; i < set_len; i++) begin
        // set 3 fills up without any last flag
        flag_last = (i == set_len - 1) && (set_no != 3);
        send_entry(pick_key(), 6'($urandom_range(0, 63)), flag_last);
      end
      sent += set_len;
      set_no++;
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    calm = 1'b0;
    wait_drained();
    repeat (2 * SET_SIZE + 20) @(posedge clk_i);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Sink side: random stalls, long ready stretches while calm.
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, calm ? 60 : 4)) @(posedge clk_i);
    end
  end

  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/skts_pkg.sv
rtl/core/skts_cell.sv
rtl/core/skts_ctrl.sv
rtl/core/stable_key_tag_sorter_core.sv
sim/sort_order_checker.sv
sim/stable_key_tag_sorter_core_tb.sv
